[src/rsn_pkg.sv]
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared widths, codes and types for the ray / segment nearest-hit block.
// ----------------------------------------------------------------------------
package rsn_pkg;

    // field widths
    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    localparam int HALF_W    = MAG_W / 2;
    localparam int PP_W      = 2 * HALF_W;
    localparam int FULL_W    = 2 * MAG_W;
    localparam int SEG_W     = 4 * COORD_W;
    localparam int REACH_W   = 12;
    localparam int ACT_W     = 9;
    localparam int LEN_W     = 20;
    localparam int IDX_OUT_W = 8;
    localparam int SLOT_IN_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [REACH_W-1:0] REACH_RESET = 12'd1500;
    localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REACH_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SEGMENTS = 1'd1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RAY  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic [MAG_W-1:0]          mag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    // one tested segment leaving the hit pipeline
    typedef struct packed {
        logic hit;
        mag_t tn;
        mag_t den;
    } cand_t;

    // running nearest hit
    typedef struct packed {
        logic found;
        mag_t tn;
        mag_t den;
    } best_t;

    // four partial products of a split multiplication
    typedef struct packed {
        logic [PP_W-1:0] hh;
        logic [PP_W-1:0] hl;
        logic [PP_W-1:0] lh;
        logic [PP_W-1:0] ll;
    } pp_t;

    function automatic pp_t pp_mul(mag_t a, mag_t b);
        pp_t p;
        p.hh = PP_W'(a[MAG_W-1:HALF_W]) * PP_W'(b[MAG_W-1:HALF_W]);
        p.hl = PP_W'(a[MAG_W-1:HALF_W]) * PP_W'(b[HALF_W-1:0]);
        p.lh = PP_W'(a[HALF_W-1:0]) * PP_W'(b[MAG_W-1:HALF_W]);
        p.ll = PP_W'(a[HALF_W-1:0]) * PP_W'(b[HALF_W-1:0]);
        return p;
    endfunction

    function automatic logic [FULL_W-1:0] pp_sum(pp_t p);
        logic [FULL_W-1:0] s;
        s = (FULL_W'(p.hh) << (2 * HALF_W)) + (FULL_W'(p.hl) << HALF_W)
          + (FULL_W'(p.lh) << HALF_W) + FULL_W'(p.ll);
        return s;
    endfunction

endpackage

[src/rsn_hit_pipe.sv]
// ----------------------------------------------------------------------------
// rsn_hit_pipe
// Segment table and six-stage intersection test, one segment per cycle.
// ----------------------------------------------------------------------------
module rsn_hit_pipe #(
    parameter int MAX_SEGMENTS = 256,
    parameter int IW           = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_addr,
    input  logic [rsn_pkg::SEG_W-1:0] wr_data,
    input  rsn_pkg::coord_t           ray_ax,
    input  rsn_pkg::coord_t           ray_ay,
    input  rsn_pkg::coord_t           ray_bx,
    input  rsn_pkg::coord_t           ray_by,
    input  logic                      iss_valid,
    input  logic [IW-1:0]             iss_idx,
    output rsn_pkg::cand_t            cand,
    output logic [IW-1:0]             cand_idx,
    output logic                      busy
);
    import rsn_pkg::*;

    localparam int NSTG = 6;

    logic [SEG_W-1:0] seg_mem [MAX_SEGMENTS];
    logic [SEG_W-1:0] rd_reg;
    logic [NSTG-1:0]  valid_reg;
    logic [IW-1:0]    idx_reg [NSTG];

    coord_t seg_sx, seg_sy, seg_ex, seg_ey;
    diff_t  rx_reg, ry_reg, sx_reg, sy_reg, cx_reg, cy_reg;
    prod_t  p_rs_reg, p_sr_reg, p_cs_reg, p_sc_reg, p_cr_reg, p_rc_reg;
    cross_t den_reg, tn_reg, un_reg;
    cross_t nden_reg, ntn_reg, nun_reg;
    logic   hit_next;
    logic   cand_hit_reg;
    mag_t   cand_tn_reg, cand_den_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[wr_addr] <= wr_data;
        end
        rd_reg <= seg_mem[iss_idx];
    end

    // valid and index travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NSTG-2:0], iss_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0] <= iss_idx;
        for (int k = 1; k < NSTG; k++)
        begin
            idx_reg[k] <= idx_reg[k-1];
        end
    end

    assign {seg_sx, seg_sy, seg_ex, seg_ey} = rd_reg;

    // differences
    always_ff @(posedge clk)
    begin
        rx_reg <= DIFF_W'(ray_bx) - DIFF_W'(ray_ax);
        ry_reg <= DIFF_W'(ray_by) - DIFF_W'(ray_ay);
        sx_reg <= DIFF_W'(seg_ex) - DIFF_W'(seg_sx);
        sy_reg <= DIFF_W'(seg_ey) - DIFF_W'(seg_sy);
        cx_reg <= DIFF_W'(seg_sx) - DIFF_W'(ray_ax);
        cy_reg <= DIFF_W'(seg_sy) - DIFF_W'(ray_ay);
    end

    // cross-product terms
    always_ff @(posedge clk)
    begin
        p_rs_reg <= PROD_W'(rx_reg) * PROD_W'(sy_reg);
        p_sr_reg <= PROD_W'(sx_reg) * PROD_W'(ry_reg);
        p_cs_reg <= PROD_W'(cx_reg) * PROD_W'(sy_reg);
        p_sc_reg <= PROD_W'(sx_reg) * PROD_W'(cy_reg);
        p_cr_reg <= PROD_W'(cx_reg) * PROD_W'(ry_reg);
        p_rc_reg <= PROD_W'(rx_reg) * PROD_W'(cy_reg);
    end

    // denominator and numerators
    always_ff @(posedge clk)
    begin
        den_reg <= CROSS_W'(p_rs_reg) - CROSS_W'(p_sr_reg);
        tn_reg  <= CROSS_W'(p_cs_reg) - CROSS_W'(p_sc_reg);
        un_reg  <= CROSS_W'(p_cr_reg) - CROSS_W'(p_rc_reg);
    end

    // make the denominator non-negative
    always_ff @(posedge clk)
    begin
        if (den_reg < 0)
        begin
            nden_reg <= -den_reg;
            ntn_reg  <= -tn_reg;
            nun_reg  <= -un_reg;
        end
        else
        begin
            nden_reg <= den_reg;
            ntn_reg  <= tn_reg;
            nun_reg  <= un_reg;
        end
    end

    // inclusive range test on t and u
    assign hit_next = valid_reg[NSTG-2] && (nden_reg != 0)
                   && (ntn_reg >= 0) && (ntn_reg <= nden_reg)
                   && (nun_reg >= 0) && (nun_reg <= nden_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_hit_reg <= 1'b0;
        end
        else
        begin
            cand_hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_tn_reg  <= ntn_reg[MAG_W-1:0];
        cand_den_reg <= nden_reg[MAG_W-1:0];
    end

    assign cand     = '{hit: cand_hit_reg, tn: cand_tn_reg, den: cand_den_reg};
    assign cand_idx = idx_reg[NSTG-1];
    assign busy     = |valid_reg;

endmodule

[src/rsn_best.sv]
// ----------------------------------------------------------------------------
// rsn_best
// Two-stage nearest-hit tracker comparing t values as exact fractions.
// ----------------------------------------------------------------------------
module rsn_best #(
    parameter int IW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  rsn_pkg::cand_t cand,
    input  logic [IW-1:0]  cand_idx,
    output rsn_pkg::best_t best,
    output logic [IW-1:0]  best_idx,
    output logic           busy
);
    import rsn_pkg::*;

    logic          a_valid_reg;
    mag_t          a_tn_reg, a_den_reg;
    logic [IW-1:0] a_idx_reg;
    pp_t           pp_cb_reg, pp_bc_reg, pp_cy_reg, pp_yc_reg;
    logic          y_won_reg;
    logic          found_reg;
    mag_t          best_tn_reg, best_den_reg;
    logic [IW-1:0] best_idx_reg;
    logic          less_old, less_y, less, win;

    // partial products against the stored best and the candidate ahead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= cand.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tn_reg  <= cand.tn;
        a_den_reg <= cand.den;
        a_idx_reg <= cand_idx;
        pp_cb_reg <= pp_mul(cand.tn, best_den_reg);
        pp_bc_reg <= pp_mul(best_tn_reg, cand.den);
        pp_cy_reg <= pp_mul(cand.tn, a_den_reg);
        pp_yc_reg <= pp_mul(a_tn_reg, cand.den);
    end

    // compare, forwarding the previous winner
    assign less_old = pp_sum(pp_cb_reg) < pp_sum(pp_bc_reg);
    assign less_y   = pp_sum(pp_cy_reg) < pp_sum(pp_yc_reg);
    assign less     = y_won_reg ? less_y : less_old;
    assign win      = a_valid_reg && (!found_reg || less);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            y_won_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
            y_won_reg <= 1'b0;
        end
        else
        begin
            y_won_reg <= win;
            if (win)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            best_tn_reg  <= '0;
            best_den_reg <= MAG_W'(1);
        end
        else if (win)
        begin
            best_tn_reg  <= a_tn_reg;
            best_den_reg <= a_den_reg;
            best_idx_reg <= a_idx_reg;
        end
    end

    assign best     = '{found: found_reg, tn: best_tn_reg, den: best_den_reg};
    assign best_idx = best_idx_reg;
    assign busy     = a_valid_reg;

`ifndef NO_ASSERTIONS
    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !clear |=> found_reg)
        else $error("nearest hit lost without a new ray");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> !found_reg)
        else $error("new ray started with a stale hit");
    a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> best_tn_reg <= best_den_reg)
        else $error("stored t above one");
`endif

endmodule

[src/rsn_div.sv]
// ----------------------------------------------------------------------------
// rsn_div
// Restoring scaler: floor(n * m / d), one bit of m per cycle.
// ----------------------------------------------------------------------------
module rsn_div #(
    parameter int MW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rsn_pkg::mag_t n,
    input  rsn_pkg::mag_t d,
    input  logic [MW-1:0] m,
    output logic          done,
    output logic [MW-1:0] q
);
    import rsn_pkg::*;

    localparam int REM_W = MAG_W + 2;
    localparam int BW    = (MW > 1) ? $clog2(MW) : 1;

    logic             busy_reg, done_reg;
    logic [BW-1:0]    bit_reg;
    logic [REM_W-1:0] rem_reg;
    logic [MW-1:0]    q_reg, m_reg;
    mag_t             n_reg, d_reg;
    logic [REM_W-1:0] t_sum, d1, d2, rem_next;
    logic [1:0]       k;

    // one quotient digit of 0, 1 or 2
    always_comb
    begin
        t_sum = (rem_reg << 1) + (m_reg[bit_reg] ? REM_W'(n_reg) : '0);
        d1    = REM_W'(d_reg);
        d2    = REM_W'(d_reg) << 1;
        if (t_sum >= d2)
        begin
            rem_next = t_sum - d2;
            k        = 2'd2;
        end
        else if (t_sum >= d1)
        begin
            rem_next = t_sum - d1;
            k        = 2'd1;
        end
        else
        begin
            rem_next = t_sum;
            k        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= BW'(MW - 1);
            end
            else if (busy_reg)
            begin
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            d_reg   <= d;
            m_reg   <= m;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= (q_reg << 1) + MW'(k);
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

[src/ray_segment_nearest_hit.sv]
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit
// Nearest wall hit of a 2-D ray against a table of line segments.
// ----------------------------------------------------------------------------
// A load transaction writes one segment into the table and gives no result.
// A ray transaction tests active segments 0..N-1 (N is active_segments,
// capped at MAX_SEGMENTS) at one segment per cycle, the rate of the table's
// single read port, through an eight-stage test and compare pipeline, then
// scales the nearest t by reach with a bit-serial divider; a miss skips the
// divider. A new transaction is taken while the previous result still waits
// in the output register; a result that still waits when the next one is
// ready holds the block until it leaves. No clearing pass is made after
// reset: only written slots may be made active.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit #(
    parameter int MAX_SEGMENTS    = 256,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsn_pkg::REACH_W-1:0]   cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic                          kind,
    input  logic [rsn_pkg::SLOT_IN_W-1:0] seg_index,
    input  rsn_pkg::coord_t               start_x,
    input  rsn_pkg::coord_t               start_y,
    input  rsn_pkg::coord_t               end_x,
    input  rsn_pkg::coord_t               end_y,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          hit,
    output logic [rsn_pkg::LEN_W-1:0]     visible_length,
    output logic [rsn_pkg::IDX_OUT_W-1:0] nearest_segment
);
    import rsn_pkg::*;

    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int AW  = (CW > ACT_W) ? CW : ACT_W;
    localparam int MW  = REACH_W + COORD_FRAC_BITS;
    localparam int XW  = (MW > LEN_W) ? MW : LEN_W;

    state_t            state_reg, state_next;
    logic [REACH_W-1:0] reach_reg;
    logic [ACT_W-1:0]  active_reg;
    coord_t            ax_reg, ay_reg, bx_reg, by_reg;
    logic [CW-1:0]     count_reg, issue_cnt_reg;
    logic              rsp_valid_reg, hit_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_OUT_W-1:0] seg_out_reg;

    logic              req_acc, ray_acc, wr_en, iss_valid, div_start, out_load;
    logic              drained;
    logic [IW-1:0]     slot;
    logic [AW-1:0]     act_ext;
    logic [CW-1:0]     count_next;
    cand_t             cand;
    logic [IW-1:0]     cand_idx, best_idx;
    best_t             best;
    logic              pipe_busy, best_busy, div_done;
    logic [MW-1:0]     reach_fx, div_q;
    logic [XW-1:0]     len_ext;
    logic [LEN_W-1:0]  len_sel;

    assign req_acc = req_valid && req_ready;
    assign ray_acc = req_acc && (kind == KIND_RAY);
    assign wr_en   = req_acc && (kind == KIND_LOAD);

    // slot = seg_index mod MAX_SEGMENTS through a constant table
    always_comb
    begin
        slot = '0;
        for (int v = 0; v < (1 << SLOT_IN_W); v++)
        begin
            if (seg_index == SLOT_IN_W'(v))
            begin
                slot = IW'(v % MAX_SEGMENTS);
            end
        end
    end

    // segment count capped at the table depth
    assign act_ext    = AW'(active_reg);
    assign count_next = (act_ext > AW'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                      : CW'(act_ext);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg  <= REACH_RESET;
            active_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REACH_LENGTH:    reach_reg  <= cfg_wdata;
                REG_ACTIVE_SEGMENTS: active_reg <= cfg_wdata[ACT_W-1:0];
                default:             ;
            endcase
        end
    end

    // ray registers
    always_ff @(posedge clk)
    begin
        if (ray_acc)
        begin
            ax_reg <= start_x;
            ay_reg <= start_y;
            bx_reg <= end_x;
            by_reg <= end_y;
        end
    end

    assign drained = !pipe_busy && !best_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (ray_acc)
                begin
                    state_next = ST_ISSUE;
                end
            ST_ISSUE:
                if (issue_cnt_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            ST_DRAIN:
                if (drained)
                begin
                    state_next = best.found ? ST_DIVIDE : ST_OUTPUT;
                end
            ST_DIVIDE:
                if (div_done)
                begin
                    state_next = ST_OUTPUT;
                end
            ST_OUTPUT:
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        iss_valid = (state_reg == ST_ISSUE) && (issue_cnt_reg != count_reg);
        div_start = (state_reg == ST_DRAIN) && drained && best.found;
        out_load  = (state_reg == ST_OUTPUT) && (!rsp_valid_reg || rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ray_acc)
            begin
                issue_cnt_reg <= '0;
                count_reg     <= count_next;
            end
            else if (iss_valid)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
        end
    end

    rsn_hit_pipe #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IW           (IW)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (slot),
        .wr_data   ({start_x, start_y, end_x, end_y}),
        .ray_ax    (ax_reg),
        .ray_ay    (ay_reg),
        .ray_bx    (bx_reg),
        .ray_by    (by_reg),
        .iss_valid (iss_valid),
        .iss_idx   (issue_cnt_reg[IW-1:0]),
        .cand      (cand),
        .cand_idx  (cand_idx),
        .busy      (pipe_busy)
    );

    rsn_best #(
        .IW (IW)
    ) u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (ray_acc),
        .cand     (cand),
        .cand_idx (cand_idx),
        .best     (best),
        .best_idx (best_idx),
        .busy     (best_busy)
    );

    assign reach_fx = MW'(reach_reg) << COORD_FRAC_BITS;

    rsn_div #(
        .MW (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (best.tn),
        .d     (best.den),
        .m     (reach_fx),
        .done  (div_done),
        .q     (div_q)
    );

    // length with saturation to the output width
    assign len_ext = best.found ? XW'(div_q) : XW'(reach_fx);
    assign len_sel = (len_ext > XW'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_reg     <= best.found;
            len_reg     <= len_sel;
            seg_out_reg <= best.found ? IDX_OUT_W'(best_idx) : '0;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign hit             = hit_reg;
    assign visible_length  = len_reg;
    assign nearest_segment = seg_out_reg;

`ifndef NO_ASSERTIONS
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> issue_cnt_reg <= count_reg)
        else $error("segment issue ran past the active count");
    a_div_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> best.found && drained)
        else $error("divider started without a settled hit");
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide phase");
`endif

endmodule
